@@ hw/rtl/jse_pkg.sv @@
// Shared types, character codes and helpers of the JSON string escaper.
package jse_pkg;

   localparam int CharWidth = 16;
   localparam int LenWidth  = 23;

   localparam logic [CharWidth-1:0] ChQuote   = 16'h0022;
   localparam logic [CharWidth-1:0] ChBslash  = 16'h005C;
   localparam logic [CharWidth-1:0] ChLowerU  = 16'h0075;
   localparam logic [LenWidth-1:0]  LenFieldMax = 23'h7FFFFF;

   // How one segment of a job expands into characters.
   typedef enum logic [2:0] {
      SEG_NONE,
      SEG_PLAIN,
      SEG_SHORT,
      SEG_UESC,
      SEG_CLOSE
   } seg_kind_type;

   // Work handed from the front to the back: opening quote, held unit, new unit.
   typedef struct packed {
      logic                 open_quote;
      seg_kind_type         held_kind;
      logic [CharWidth-1:0] held;
      seg_kind_type         unit_kind;
      logic [CharWidth-1:0] unit;
   } job_type;

   typedef struct packed {
      logic [CharWidth-1:0] out_char;
      logic                 last_of_string;
      logic [LenWidth-1:0]  escaped_length;
      logic                 fits_in_bytes;
   } result_type;

   function automatic logic [CharWidth-1:0] hex_digit(input logic [3:0] nib);
      logic [CharWidth-1:0] d;
      if (nib < 4'd10) begin
         d = 16'h0030 + {12'd0, nib};
      end else begin
         d = 16'h0057 + {12'd0, nib};
      end
      return d;
   endfunction

   function automatic logic [2:0] seg_last_pos(input seg_kind_type kind);
      logic [2:0] p;
      unique case (kind)
         SEG_SHORT: p = 3'd1;
         SEG_UESC:  p = 3'd5;
         default:   p = 3'd0;
      endcase
      return p;
   endfunction

   function automatic logic [CharWidth-1:0] seg_char(input seg_kind_type kind,
                                                      input logic [CharWidth-1:0] val,
                                                      input logic [2:0] pos);
      logic [CharWidth-1:0] c;
      c = val;
      unique case (kind)
         SEG_SHORT: c = (pos == 3'd0) ? ChBslash : val;
         SEG_UESC: begin
            unique case (pos)
               3'd0:    c = ChBslash;
               3'd1:    c = ChLowerU;
               3'd2:    c = hex_digit(val[15:12]);
               3'd3:    c = hex_digit(val[11:8]);
               3'd4:    c = hex_digit(val[7:4]);
               default: c = hex_digit(val[3:0]);
            endcase
         end
         SEG_CLOSE: c = ChQuote;
         default:   c = val;
      endcase
      return c;
   endfunction

endpackage

@@ hw/rtl/json_string_escaper_unit.sv @@
// Top level of the streaming JSON string escaper for 16-bit code units.
//
// Input queue: present req_command/req_code_unit with push; the item is
// taken on a rising edge where push is high and full is low. Command 0
// carries one code unit, command 1 ends the string.
// Result queue: while empty is low the oldest character sits on the rsp_
// ports; pop takes it. The closing quote has rsp_last_of_string set and
// carries rsp_escaped_length (saturating) and rsp_fits_in_bytes.
// Structure: a front end classifies each item and tracks the open string
// and a held high surrogate; a 4-entry job queue feeds a back end that
// expands each job into characters; a 2-entry result queue holds output.
// Path: a taken item goes to the job queue, the back end's working register
// and the result queue. One character per cycle leaves the back end while
// the result queue has room; an escape is two or six characters, the worst
// item (held escape plus new escape) 12 characters.
// When pop stays low the result queue and then the job queue fill and full
// rises; nothing is lost. Reset (synchronous) empties both queues and
// returns to "no string open", count zero, all characters narrow.
module json_string_escaper_unit import jse_pkg::*; #(
   parameter int MAX_UNITS = 1048576
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic                 req_command,
   input  logic [CharWidth-1:0] req_code_unit,
   output logic                 empty,
   input  logic                 pop,
   output logic [CharWidth-1:0] rsp_out_char,
   output logic                 rsp_last_of_string,
   output logic [LenWidth-1:0]  rsp_escaped_length,
   output logic                 rsp_fits_in_bytes
);
   localparam int JobDepth = 4;
   localparam int ResDepth = 2;

   logic       accept, job_push, job_full, job_empty, job_pop;
   job_type    job_wr, job_rd;
   logic       res_push, res_full;
   result_type res_wr, res_rd;

   // full comes straight from the job queue, so an item always has a slot
   assign full   = job_full;
   assign accept = push & ~job_full;

   jse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_command),
      .code_unit (req_code_unit),
      .job_push  (job_push),
      .job       (job_wr)
   );

   jse_fifo #(.DEPTH(JobDepth), .WIDTH($bits(job_type))) u_job_q (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .wr_data (job_wr),
      .full    (job_full),
      .pop     (job_pop),
      .rd_data (job_rd),
      .empty   (job_empty)
   );

   jse_back #(.MAX_UNITS(MAX_UNITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (job_rd),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res_wr)
   );

   jse_fifo #(.DEPTH(ResDepth), .WIDTH($bits(result_type))) u_res_q (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_wr),
      .full    (res_full),
      .pop     (pop),
      .rd_data (res_rd),
      .empty   (empty)
   );

   assign rsp_out_char       = res_rd.out_char;
   assign rsp_last_of_string = res_rd.last_of_string;
   assign rsp_escaped_length = res_rd.escaped_length;
   assign rsp_fits_in_bytes  = res_rd.fits_in_bytes;
endmodule

@@ hw/rtl/jse_fifo.sv @@
// Small register FIFO used for the job queue and the result queue.
module jse_fifo import jse_pkg::*; #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end
endmodule

@@ hw/rtl/jse_front.sv @@
// Front end: accepts items, tracks the open string and held surrogate, builds jobs.
module jse_front import jse_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 command,
   input  logic [CharWidth-1:0] code_unit,
   output logic                 job_push,
   output job_type              job
);
   logic                 opened_ff, opened_in;
   logic                 pending_ff, pending_in;
   logic [CharWidth-1:0] held_ff, held_in;
   logic [CharWidth-1:0] short_ch;
   logic                 is_low, is_high, needs_uesc;

   function automatic logic [CharWidth-1:0] short_code(input logic [CharWidth-1:0] ch);
      logic [CharWidth-1:0] s;
      unique case (ch)
         16'h0022: s = 16'h0022;
         16'h005C: s = 16'h005C;
         16'h0008: s = 16'h0062;
         16'h000C: s = 16'h0066;
         16'h000A: s = 16'h006E;
         16'h000D: s = 16'h0072;
         16'h0009: s = 16'h0074;
         default:  s = '0;
      endcase
      return s;
   endfunction

   assign short_ch   = short_code(code_unit);
   assign is_low     = (code_unit >= 16'hDC00) && (code_unit <= 16'hDFFF);
   assign is_high    = (code_unit >= 16'hD800) && (code_unit <= 16'hDBFF);
   assign needs_uesc = (code_unit < 16'h0020) || (code_unit == 16'h007F) || is_low;

   always_comb begin
      job            = '0;
      job.open_quote = ~opened_ff;
      job.held_kind  = SEG_NONE;
      job.held       = held_ff;
      job.unit_kind  = SEG_NONE;
      job.unit       = code_unit;
      opened_in      = opened_ff;
      pending_in     = pending_ff;
      held_in        = held_ff;
      if (accept) begin
         opened_in = 1'b1;
         if (command) begin
            job.held_kind = pending_ff ? SEG_UESC : SEG_NONE;
            job.unit_kind = SEG_CLOSE;
            opened_in     = 1'b0;
            pending_in    = 1'b0;
            held_in       = '0;
         end else if (pending_ff && is_low) begin
            // valid pair passes through untouched
            job.held_kind = SEG_PLAIN;
            job.unit_kind = SEG_PLAIN;
            pending_in    = 1'b0;
            held_in       = '0;
         end else begin
            if (pending_ff) begin
               job.held_kind = SEG_UESC;
            end
            pending_in = 1'b0;
            held_in    = '0;
            if (short_ch != '0) begin
               job.unit_kind = SEG_SHORT;
               job.unit      = short_ch;
            end else if (needs_uesc) begin
               job.unit_kind = SEG_UESC;
            end else if (is_high) begin
               pending_in = 1'b1;
               held_in    = code_unit;
            end else begin
               job.unit_kind = SEG_PLAIN;
            end
         end
      end
   end

   // a held high surrogate alone pushes no job unless the opening quote is due
   assign job_push = accept & (job.open_quote | (job.held_kind != SEG_NONE) |
                               (job.unit_kind != SEG_NONE));

   always_ff @(posedge clock) begin
      if (reset) begin
         opened_ff  <= 1'b0;
         pending_ff <= 1'b0;
         held_ff    <= '0;
      end else begin
         opened_ff  <= opened_in;
         pending_ff <= pending_in;
         held_ff    <= held_in;
      end
   end
endmodule

@@ hw/rtl/jse_back.sv @@
// Back end: expands jobs into characters, one per cycle while res_full is low, and keeps length and width.
module jse_back import jse_pkg::*; #(
   parameter int MAX_UNITS = 1048576
) (
   input  logic       clock,
   input  logic       reset,
   input  job_type    job,
   input  logic       job_empty,
   output logic       job_pop,
   input  logic       res_full,
   output logic       res_push,
   output result_type res
);
   localparam longint unsigned CapWide = 64'(6) * 64'(MAX_UNITS) + 64'(2);
   localparam logic [LenWidth-1:0] LenCap =
      (CapWide > 64'(LenFieldMax)) ? LenFieldMax : LenWidth'(CapWide);

   logic                 w_valid_ff, w_valid_in;
   job_type              w_ff, w_in;
   logic [2:0]           pos_ff, pos_in;
   logic [LenWidth-1:0]  count_ff, count_in;
   logic                 narrow_ff, narrow_in;

   seg_kind_type         cur_kind;
   logic [CharWidth-1:0] cur_val, cur_ch;
   logic                 in_open, in_held, seg_last, job_last, is_close, emit;
   logic [LenWidth-1:0]  count_next;

   assign in_open = w_ff.open_quote;
   assign in_held = ~w_ff.open_quote & (w_ff.held_kind != SEG_NONE);

   always_comb begin
      if (in_open) begin
         cur_kind = SEG_PLAIN;
         cur_val  = ChQuote;
      end else if (in_held) begin
         cur_kind = w_ff.held_kind;
         cur_val  = w_ff.held;
      end else begin
         cur_kind = w_ff.unit_kind;
         cur_val  = w_ff.unit;
      end
   end

   assign cur_ch   = seg_char(cur_kind, cur_val, pos_ff);
   assign seg_last = (pos_ff == seg_last_pos(cur_kind));
   assign job_last = seg_last &
                     ((~in_open & ~in_held) |
                      (in_held & (w_ff.unit_kind == SEG_NONE)) |
                      (in_open & (w_ff.held_kind == SEG_NONE) &
                       (w_ff.unit_kind == SEG_NONE)));
   assign is_close   = ~in_open & ~in_held & (w_ff.unit_kind == SEG_CLOSE);
   assign emit       = w_valid_ff & ~res_full;
   assign count_next = (count_ff < LenCap) ? count_ff + 1'b1 : count_ff;
   assign job_pop    = ~job_empty & (~w_valid_ff | (emit & job_last));

   assign res_push           = emit;
   assign res.out_char       = cur_ch;
   assign res.last_of_string = is_close;
   assign res.escaped_length = is_close ? count_next : '0;
   assign res.fits_in_bytes  = is_close & narrow_ff;

   always_comb begin
      w_valid_in = w_valid_ff;
      w_in       = w_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      narrow_in  = narrow_ff;
      if (emit) begin
         if (is_close) begin
            count_in  = '0;
            narrow_in = 1'b1;
         end else begin
            count_in  = count_next;
            narrow_in = narrow_ff & (cur_ch[15:8] == '0);
         end
         if (!seg_last) begin
            pos_in = pos_ff + 1'b1;
         end else begin
            pos_in = '0;
            if (in_open) begin
               w_in.open_quote = 1'b0;
            end else if (in_held) begin
               w_in.held_kind = SEG_NONE;
            end
         end
         if (job_last) begin
            w_valid_in = 1'b0;
         end
      end
      if (job_pop) begin
         w_valid_in = 1'b1;
         w_in       = job;
         pos_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
         pos_ff     <= '0;
         count_ff   <= '0;
         narrow_ff  <= 1'b1;
      end else begin
         w_valid_ff <= w_valid_in;
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         narrow_ff  <= narrow_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end
endmodule

@@ tb/tb_json_string_escaper_unit.sv @@
// Self-checking testbench for the streaming JSON string escaper.

// Command field of one input item.
typedef enum bit {
   CMD_UNIT = 1'b0,
   CMD_END  = 1'b1
} cmd_kind_type;

// Predicts the escaped character stream and checks each popped character.
class escape_scoreboard;
   localparam logic [15:0] ChBackspace = 16'h0008;
   localparam logic [15:0] ChTab       = 16'h0009;
   localparam logic [15:0] ChNewline   = 16'h000A;
   localparam logic [15:0] ChFormFeed  = 16'h000C;
   localparam logic [15:0] ChReturn    = 16'h000D;
   localparam logic [15:0] ChSpace     = 16'h0020;
   localparam logic [15:0] ChDel       = 16'h007F;
   localparam logic [15:0] ChLowerB    = 16'h0062;
   localparam logic [15:0] ChLowerF    = 16'h0066;
   localparam logic [15:0] ChLowerN    = 16'h006E;
   localparam logic [15:0] ChLowerR    = 16'h0072;
   localparam logic [15:0] ChLowerT    = 16'h0074;

   jse_pkg::result_type expected_chars[$];
   bit                  opened;
   bit                  pending_high;
   logic [15:0]         held_unit;
   logic [22:0]         char_count;
   bit                  all_narrow;
   logic [22:0]         length_cap;
   int                  errors;

   function new(int max_units);
      longint cap;
      cap = 6 * longint'(max_units) + 2;
      if (cap > longint'(jse_pkg::LenFieldMax)) begin
         cap = longint'(jse_pkg::LenFieldMax);
      end
      length_cap = cap[22:0];
      errors     = 0;
      close_string();
   endfunction

   function void close_string();
      opened       = 1'b0;
      pending_high = 1'b0;
      held_unit    = '0;
      char_count   = '0;
      all_narrow   = 1'b1;
   endfunction

   static function bit is_low_surrogate(logic [15:0] u);
      return u >= 16'hDC00 && u <= 16'hDFFF;
   endfunction

   static function bit is_high_surrogate(logic [15:0] u);
      return u >= 16'hD800 && u <= 16'hDBFF;
   endfunction

   function void emit(logic [15:0] c);
      jse_pkg::result_type r;
      r.out_char       = c;
      r.last_of_string = 1'b0;
      r.escaped_length = '0;
      r.fits_in_bytes  = 1'b0;
      expected_chars.push_back(r);
      if (char_count < length_cap) char_count++;
      if (c > 16'h00FF) all_narrow = 1'b0;
   endfunction

   function void emit_uescape(logic [15:0] u);
      logic [3:0] nib;
      emit(jse_pkg::ChBslash);
      emit(jse_pkg::ChLowerU);
      for (int i = 3; i >= 0; i--) begin
         nib = u[i*4 +: 4];
         emit(nib < 4'd10 ? 16'h0030 + nib : 16'h0061 + (nib - 4'd10));
      end
   endfunction

   function void escape_unit(logic [15:0] u);
      logic [15:0] code;
      case (u)
         jse_pkg::ChQuote:  code = jse_pkg::ChQuote;
         jse_pkg::ChBslash: code = jse_pkg::ChBslash;
         ChBackspace:       code = ChLowerB;
         ChFormFeed:        code = ChLowerF;
         ChNewline:         code = ChLowerN;
         ChReturn:          code = ChLowerR;
         ChTab:             code = ChLowerT;
         default:           code = '0;
      endcase
      if (code != '0) begin
         emit(jse_pkg::ChBslash);
         emit(code);
      end else if (u < ChSpace || u == ChDel || is_low_surrogate(u)) begin
         emit_uescape(u);
      end else if (is_high_surrogate(u)) begin
         pending_high = 1'b1;
         held_unit    = u;
      end else begin
         emit(u);
      end
   endfunction

   // One accepted input item: queue every character it causes.
   function void note_item(cmd_kind_type cmd, logic [15:0] u);
      if (!opened) begin
         emit(jse_pkg::ChQuote);
         opened = 1'b1;
      end
      if (cmd == CMD_END) begin
         if (pending_high) emit_uescape(held_unit);
         emit(jse_pkg::ChQuote);
         expected_chars[$].last_of_string = 1'b1;
         expected_chars[$].escaped_length = char_count;
         expected_chars[$].fits_in_bytes  = all_narrow;
         close_string();
      end else begin
         if (pending_high) begin
            pending_high = 1'b0;
            if (is_low_surrogate(u)) begin
               emit(held_unit);
               emit(u);
               held_unit = '0;
               return;
            end
            emit_uescape(held_unit);
            held_unit = '0;
         end
         escape_unit(u);
      end
   endfunction

   function void check_result(jse_pkg::result_type got);
      jse_pkg::result_type want;
      if (expected_chars.size() == 0) begin
         $error("unexpected character: out_char %h", got.out_char);
         errors++;
         return;
      end
      want = expected_chars.pop_front();
      if (got.out_char !== want.out_char) begin
         $error("out_char: expected %h, actual %h", want.out_char, got.out_char);
         errors++;
      end
      if (got.last_of_string !== want.last_of_string) begin
         $error("last_of_string: expected %b, actual %b",
                want.last_of_string, got.last_of_string);
         errors++;
      end
      if (got.escaped_length !== want.escaped_length) begin
         $error("escaped_length: expected %0d, actual %0d",
                want.escaped_length, got.escaped_length);
         errors++;
      end
      if (got.fits_in_bytes !== want.fits_in_bytes) begin
         $error("fits_in_bytes: expected %b, actual %b",
                want.fits_in_bytes, got.fits_in_bytes);
         errors++;
      end
   endfunction

   function int pending();
      return expected_chars.size();
   endfunction
endclass

module tb_json_string_escaper_unit;
   import jse_pkg::*;

   localparam int MaxUnits    = 1048576;
   localparam int ItemsTarget = 310;
   // Final stretch with no idling on either side.
   localparam int QuietItems  = 50;
   // Receiver hold-off long enough to fill the job and result queues.
   localparam int LongHold    = 300;
   // Worst item expands to 12 characters; margin in which strays are still caught.
   localparam int DrainCycles = 40;
   // Watchdog limit, set well above the slowest legal run.
   localparam int CycleLimit  = 500000;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   logic                 req_command = 1'b0;
   logic [CharWidth-1:0] req_code_unit = '0;
   logic                 empty;
   logic                 pop = 1'b0;
   logic [CharWidth-1:0] rsp_out_char;
   logic                 rsp_last_of_string;
   logic [LenWidth-1:0]  rsp_escaped_length;
   logic                 rsp_fits_in_bytes;

   // Flags handed from the sender to the receiver are written with NBAs.
   bit quiet = 1'b0;
   bit hold_wanted = 1'b0;
   bit hold_done = 1'b0;
   bit sender_idles = 1'b1;
   int items_sent = 0;
   int cycle_count = 0;

   escape_scoreboard sb = new(MaxUnits);

   json_string_escaper_unit #(.MAX_UNITS(MaxUnits)) dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_command        (req_command),
      .req_code_unit      (req_code_unit),
      .empty              (empty),
      .pop                (pop),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_of_string (rsp_last_of_string),
      .rsp_escaped_length (rsp_escaped_length),
      .rsp_fits_in_bytes  (rsp_fits_in_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result monitor. Sampling in the active region at the edge sees the
   // pre-edge values of empty and the rsp_ ports, so pop && !empty is
   // exactly the handshake that the block honors at this edge.
   always @(posedge clock) begin
      result_type got;
      if (!reset && pop && !empty) begin
         got.out_char       = rsp_out_char;
         got.last_of_string = rsp_last_of_string;
         got.escaped_length = rsp_escaped_length;
         got.fits_in_bytes  = rsp_fits_in_bytes;
         sb.check_result(got);
      end
   end

   // Present one item and hold it until the block takes it. The expected
   // characters are queued at the accepting edge, before the first of them
   // can show up on the rsp_ side.
   task automatic send_item(cmd_kind_type cmd, logic [CharWidth-1:0] u);
      push          <= 1'b1;
      req_command   <= cmd;
      req_code_unit <= u;
      do @(posedge clock); while (full);
      sb.note_item(cmd, u);
      items_sent++;
      // Random gap after the item; push drops here and rises only in a
      // later time step, so there is never a same-step drop and raise.
      if (!quiet && sender_idles && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Unit mix for well-formed strings. A returned high surrogate with
   // want_pair set is followed by a random low surrogate.
   function automatic logic [CharWidth-1:0] pick_unit(output bit want_pair);
      int sel;
      logic [CharWidth-1:0] specials [7] = '{16'h0022, 16'h005C, 16'h0008, 16'h000C,
                                             16'h000A, 16'h000D, 16'h0009};
      sel       = $urandom_range(0, 99);
      want_pair = 1'b0;
      if (sel < 36)      return 16'($urandom_range(16'h0020, 16'h007E));
      else if (sel < 46) return specials[$urandom_range(0, 6)];
      else if (sel < 54) return 16'($urandom_range(16'h0000, 16'h001F));
      else if (sel < 57) return 16'h007F;
      else if (sel < 65) return 16'($urandom_range(16'h0080, 16'h00FF));
      else if (sel < 73) return 16'($urandom_range(16'h0100, 16'hD7FF));
      else if (sel < 78) return 16'($urandom_range(16'hE000, 16'hFFFF));
      else if (sel < 90) begin
         want_pair = 1'b1;
         return 16'($urandom_range(16'hD800, 16'hDBFF));
      end
      else if (sel < 95) return 16'($urandom_range(16'hD800, 16'hDBFF));
      else               return 16'($urandom_range(16'hDC00, 16'hDFFF));
   endfunction

   // Receiver: random pop bursts, one long hold-off on request, and
   // steady popping once the final stretch starts.
   initial begin
      do @(posedge clock); while (reset);
      forever begin
         if (hold_wanted && !hold_done) begin
            pop <= 1'b0;
            repeat (LongHold) @(posedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 2) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            pop <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // Stimulus
   initial begin
      int  len;
      bit  noise;
      bit  want_pair;
      logic [CharWidth-1:0] u;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty string: the end command alone gives two quotes.
      send_item(CMD_END, 16'hFFFF);

      // Field extremes, every short escape, control, DEL, space, byte edge.
      send_item(CMD_UNIT, 16'h0000);
      send_item(CMD_UNIT, 16'hFFFF);
      send_item(CMD_UNIT, 16'h0022);
      send_item(CMD_UNIT, 16'h005C);
      send_item(CMD_UNIT, 16'h0008);
      send_item(CMD_UNIT, 16'h000C);
      send_item(CMD_UNIT, 16'h000A);
      send_item(CMD_UNIT, 16'h000D);
      send_item(CMD_UNIT, 16'h0009);
      send_item(CMD_UNIT, 16'h001F);
      send_item(CMD_UNIT, 16'h007F);
      send_item(CMD_UNIT, 16'h0020);
      send_item(CMD_UNIT, 16'h00FF);
      send_item(CMD_UNIT, 16'h0100);
      send_item(CMD_END, 16'h0000);

      // Surrogates: valid pairs at both ends of the range, a lone low,
      // a held high followed by a control (held escape plus new escape,
      // the largest expansion), high followed by high, and a high still
      // held when the string ends.
      send_item(CMD_UNIT, 16'hD800);
      send_item(CMD_UNIT, 16'hDC00);
      send_item(CMD_UNIT, 16'hDBFF);
      send_item(CMD_UNIT, 16'hDFFF);
      send_item(CMD_UNIT, 16'hDFFF);
      send_item(CMD_UNIT, 16'hD801);
      send_item(CMD_UNIT, 16'h0001);
      send_item(CMD_UNIT, 16'hDBFF);
      send_item(CMD_UNIT, 16'hD800);
      send_item(CMD_END, 16'h1234);

      // Random strings. Ask the receiver for its long hold-off right away
      // while the sender keeps pushing, so both queues fill and full rises.
      hold_wanted <= 1'b1;
      while (items_sent < ItemsTarget) begin
         if (items_sent >= ItemsTarget - QuietItems) quiet <= 1'b1;
         sender_idles = $urandom_range(0, 2) != 0;
         // Mostly short strings, now and then a longer one.
         len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                             : $urandom_range(0, 8);
         // A tenth of the strings are raw noise over the whole unit range.
         noise = $urandom_range(0, 9) == 0;
         for (int i = 0; i < len; i++) begin
            if (noise) begin
               send_item(CMD_UNIT, 16'($urandom_range(0, 16'hFFFF)));
            end else begin
               u = pick_unit(want_pair);
               send_item(CMD_UNIT, u);
               if (want_pair) begin
                  send_item(CMD_UNIT, 16'($urandom_range(16'hDC00, 16'hDFFF)));
               end
            end
         end
         // The unit field of an end command is ignored; keep it random.
         send_item(CMD_END, 16'($urandom_range(0, 16'hFFFF)));
      end
      push <= 1'b0;

      // Drain: everything predicted must arrive, then allow a margin in
      // which any stray character would still be flagged by the monitor.
      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/jse_pkg.sv
hw/rtl/jse_fifo.sv
hw/rtl/jse_front.sv
hw/rtl/jse_back.sv
hw/rtl/json_string_escaper_unit.sv
tb/tb_json_string_escaper_unit.sv
